// ===== hdl/rrc_pkg.sv =====
// shared types, constants and register codes of the random replacement cache
`default_nettype none

package rrc_pkg;

    localparam int DEPTH_DEFAULT       = 8;
    localparam int KEY_WIDTH_DEFAULT   = 32;
    localparam int VALUE_WIDTH_DEFAULT = 32;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int CAP_REG_W   = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_CAPACITY    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RANDOM_SEED = 2'd1;

    localparam logic [CAP_REG_W-1:0] CAP_RESET = 4'd8;

    // replacement lfsr
    localparam int LFSR_W = 16;
    localparam logic [LFSR_W-1:0] LFSR_MASK  = 16'hB400;
    localparam logic [LFSR_W-1:0] SEED_RESET = 16'd44257;

    // request kinds
    localparam logic KIND_PUT = 1'b0;
    localparam logic KIND_GET = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_MISS,
        ST_EVICT_RD,
        ST_EVICT_WR
    } t_state;

    typedef struct packed {
        logic              load;
        logic [LFSR_W-1:0] seed;
        logic              step;
    } t_victim_ctrl;

endpackage

`default_nettype wire

// ===== hdl/rrc_entry_ram.sv =====
// entry memory: one write port, one registered read port
`default_nettype none

module rrc_entry_ram #(
    parameter int DEPTH = rrc_pkg::DEPTH_DEFAULT,
    parameter int WIDTH = rrc_pkg::KEY_WIDTH_DEFAULT + rrc_pkg::VALUE_WIDTH_DEFAULT,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/rrc_victim.sv =====
// replacement lfsr and victim slot selection
`default_nettype none

module rrc_victim #(
    parameter int CAP_W  = 4,
    parameter int ADDR_W = 3
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire rrc_pkg::t_victim_ctrl i_ctrl,
    input  wire logic [CAP_W-1:0]      i_cap,
    output logic      [ADDR_W-1:0]     o_slot
);

    localparam int LW = rrc_pkg::LFSR_W;

    logic [LW-1:0]       r_lfsr;
    logic [LW-1:0]       n_lfsr;
    logic [LW+CAP_W-1:0] prod;
    logic [ADDR_W-1:0]   r_slot;

    always_comb begin
        n_lfsr = (r_lfsr >> 1) ^ (r_lfsr[0] ? rrc_pkg::LFSR_MASK : '0);
        prod   = (LW+CAP_W)'(n_lfsr) * (LW+CAP_W)'(i_cap);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= rrc_pkg::SEED_RESET;
        end else if (i_ctrl.load) begin
            r_lfsr <= i_ctrl.seed;
        end else if (i_ctrl.step) begin
            r_lfsr <= n_lfsr;
        end
    end

    // slot is below the capacity, so the low product bits above the fraction suffice
    always_ff @(posedge i_clk) begin
        if (i_ctrl.step) begin
            r_slot <= prod[LW+ADDR_W-1:LW];
        end
    end

    assign o_slot = r_slot;

endmodule

`default_nettype wire

// ===== hdl/random_replacement_cache.sv =====
// top level of the fully associative key-value cache with random replacement
//
// A request is taken at a clock edge with i_start high and o_busy low: i_kind selects
// put (store i_key/i_value) or get (look up i_key). Entries live in one synchronous
// memory and are scanned one slot per cycle from slot 0, stopping at the first match.
// A hit ends the scan at the matching slot; a get miss or a put into a free slot goes
// to ST_MISS after all entries (straight away when empty); a put that evicts steps
// the lfsr and multiplies in ST_MISS, then reads the victim key in ST_EVICT_RD and
// writes in ST_EVICT_WR. Requests are handled one at a time. The result appears for
// exactly one cycle with o_result_valid, in the cycle in which o_busy falls; a new
// request may be taken in that same cycle. The receiver cannot stall, so each result
// must be taken when strobed. Configuration: i_cfg_we writes register i_cfg_index (0
// capacity, 1 random seed, which also loads the lfsr) from i_cfg_data; the user writes
// only while no request is in flight, which the block does not enforce. Reset clears
// the entry count, sets capacity 8 and the lfsr to the seed reset value; the memory
// needs no clearing since only slots below the count are ever read.
`default_nettype none

module random_replacement_cache #(
    parameter int DEPTH       = rrc_pkg::DEPTH_DEFAULT,
    parameter int KEY_WIDTH   = rrc_pkg::KEY_WIDTH_DEFAULT,
    parameter int VALUE_WIDTH = rrc_pkg::VALUE_WIDTH_DEFAULT,
    parameter int CNT_W       = $clog2(DEPTH + 1)
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    output logic                                 o_busy,
    input  wire logic                            i_kind,
    input  wire logic [KEY_WIDTH-1:0]            i_key,
    input  wire logic [VALUE_WIDTH-1:0]          i_value,
    input  wire logic                            i_cfg_we,
    input  wire logic [rrc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [rrc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                                 o_result_valid,
    output logic                                 o_hit,
    output logic      [VALUE_WIDTH-1:0]          o_read_value,
    output logic                                 o_evicted,
    output logic      [KEY_WIDTH-1:0]            o_evicted_key,
    output logic      [CNT_W-1:0]                o_entry_count
);

    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int ENTRY_W = KEY_WIDTH + VALUE_WIDTH;
    localparam int CAP_W   = (CNT_W > rrc_pkg::CAP_REG_W) ? CNT_W : rrc_pkg::CAP_REG_W;

    rrc_pkg::t_state r_state, n_state;

    logic                          r_kind, n_kind;
    logic [KEY_WIDTH-1:0]          r_key, n_key;
    logic [VALUE_WIDTH-1:0]        r_value, n_value;
    logic [ADDR_W-1:0]             r_idx, n_idx;
    logic [CNT_W-1:0]              r_count, n_count;
    logic [rrc_pkg::CAP_REG_W-1:0] r_capacity, n_capacity;
    logic                          r_done, n_done;
    logic                          r_hit, n_hit;
    logic [VALUE_WIDTH-1:0]        r_read_value, n_read_value;
    logic                          r_evicted, n_evicted;
    logic [KEY_WIDTH-1:0]          r_evicted_key, n_evicted_key;
    logic [CNT_W-1:0]              r_entry_count, n_entry_count;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [ENTRY_W-1:0]    ram_rdata;
    logic [KEY_WIDTH-1:0]  rd_key;
    logic [VALUE_WIDTH-1:0] rd_value;

    rrc_pkg::t_victim_ctrl vctrl;
    logic [ADDR_W-1:0]     victim_slot;

    logic [CAP_W-1:0] eff_cap;
    logic             match;
    logic             last;
    logic             room;

    rrc_entry_ram #(
        .DEPTH  (DEPTH),
        .WIDTH  (ENTRY_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rrc_victim #(
        .CAP_W  (CAP_W),
        .ADDR_W (ADDR_W)
    ) u_victim (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (vctrl),
        .i_cap   (eff_cap),
        .o_slot  (victim_slot)
    );

    assign rd_key   = ram_rdata[ENTRY_W-1:VALUE_WIDTH];
    assign rd_value = ram_rdata[VALUE_WIDTH-1:0];

    always_comb begin
        if (r_capacity == '0) begin
            eff_cap = CAP_W'(1);
        end else if (CAP_W'(r_capacity) > CAP_W'(DEPTH)) begin
            eff_cap = CAP_W'(DEPTH);
        end else begin
            eff_cap = CAP_W'(r_capacity);
        end
    end

    assign match = (rd_key == r_key);
    assign last  = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
    assign room  = (CAP_W'(r_count) < eff_cap);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rrc_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = (r_count == '0) ? rrc_pkg::ST_MISS : rrc_pkg::ST_CMP;
                end
            end
            rrc_pkg::ST_CMP: begin
                if (match) begin
                    n_state = rrc_pkg::ST_IDLE;
                end else if (last) begin
                    n_state = rrc_pkg::ST_MISS;
                end
            end
            rrc_pkg::ST_MISS: begin
                if (r_kind == rrc_pkg::KIND_GET || room) begin
                    n_state = rrc_pkg::ST_IDLE;
                end else begin
                    n_state = rrc_pkg::ST_EVICT_RD;
                end
            end
            rrc_pkg::ST_EVICT_RD: n_state = rrc_pkg::ST_EVICT_WR;
            rrc_pkg::ST_EVICT_WR: n_state = rrc_pkg::ST_IDLE;
            default:              n_state = rrc_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_kind        = r_kind;
        n_key         = r_key;
        n_value       = r_value;
        n_idx         = r_idx;
        n_count       = r_count;
        n_capacity    = r_capacity;
        n_done        = 1'b0;
        n_hit         = r_hit;
        n_read_value  = r_read_value;
        n_evicted     = r_evicted;
        n_evicted_key = r_evicted_key;
        n_entry_count = r_entry_count;
        ram_we        = 1'b0;
        ram_waddr     = r_idx;
        ram_wdata     = {r_key, r_value};
        ram_raddr     = r_idx;
        vctrl.load    = i_cfg_we && (i_cfg_index == rrc_pkg::REG_RANDOM_SEED);
        vctrl.seed    = i_cfg_data[rrc_pkg::LFSR_W-1:0];
        vctrl.step    = 1'b0;

        if (i_cfg_we && i_cfg_index == rrc_pkg::REG_CAPACITY) begin
            n_capacity = i_cfg_data[rrc_pkg::CAP_REG_W-1:0];
        end

        case (r_state)
            rrc_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_kind    = i_kind;
                    n_key     = i_key;
                    n_value   = i_value;
                    n_idx     = '0;
                    ram_raddr = '0;
                end
            end
            rrc_pkg::ST_CMP: begin
                if (match) begin
                    n_hit         = 1'b1;
                    n_read_value  = (r_kind == rrc_pkg::KIND_GET) ? rd_value : '0;
                    n_evicted     = 1'b0;
                    n_evicted_key = '0;
                    n_entry_count = r_count;
                    n_done        = 1'b1;
                    ram_we        = (r_kind == rrc_pkg::KIND_PUT);
                end else if (!last) begin
                    // issue the next slot while this one is compared
                    n_idx     = r_idx + ADDR_W'(1);
                    ram_raddr = r_idx + ADDR_W'(1);
                end
            end
            rrc_pkg::ST_MISS: begin
                n_hit         = 1'b0;
                n_read_value  = '0;
                n_evicted     = 1'b0;
                n_evicted_key = '0;
                if (r_kind == rrc_pkg::KIND_GET) begin
                    n_entry_count = r_count;
                    n_done        = 1'b1;
                end else if (room) begin
                    ram_we        = 1'b1;
                    ram_waddr     = r_count[ADDR_W-1:0];
                    n_count       = r_count + CNT_W'(1);
                    n_entry_count = r_count + CNT_W'(1);
                    n_done        = 1'b1;
                end else begin
                    vctrl.step = 1'b1;
                end
            end
            rrc_pkg::ST_EVICT_RD: begin
                ram_raddr = victim_slot;
            end
            rrc_pkg::ST_EVICT_WR: begin
                ram_we        = 1'b1;
                ram_waddr     = victim_slot;
                n_hit         = 1'b0;
                n_read_value  = '0;
                n_evicted     = 1'b1;
                n_evicted_key = rd_key;
                n_entry_count = r_count;
                n_done        = 1'b1;
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= rrc_pkg::ST_IDLE;
            r_count    <= '0;
            r_capacity <= rrc_pkg::CAP_RESET;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_capacity <= n_capacity;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind        <= n_kind;
        r_key         <= n_key;
        r_value       <= n_value;
        r_idx         <= n_idx;
        r_hit         <= n_hit;
        r_read_value  <= n_read_value;
        r_evicted     <= n_evicted;
        r_evicted_key <= n_evicted_key;
        r_entry_count <= n_entry_count;
    end

    assign o_busy         = (r_state != rrc_pkg::ST_IDLE);
    assign o_result_valid = r_done;
    assign o_hit          = r_hit;
    assign o_read_value   = r_read_value;
    assign o_evicted      = r_evicted;
    assign o_evicted_key  = r_evicted_key;
    assign o_entry_count  = r_entry_count;

`ifndef SYNTH
    a_strobe_single : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for more than one cycle");

    a_busy_after_start : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("request accepted but block not busy");

    a_evict_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rrc_pkg::ST_EVICT_WR) |=> (o_result_valid && o_evicted && !o_hit))
        else $error("eviction did not produce an evicting result");

    a_count_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_count != $past(r_count)) |->
            (r_count == $past(r_count) + CNT_W'(1)))
        else $error("entry count changed by other than one");

    a_victim_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rrc_pkg::ST_EVICT_RD) |-> (CAP_W'(victim_slot) < eff_cap))
        else $error("victim slot outside effective capacity");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the random replacement cache: queued requests, shadow predictor
`timescale 1ns / 1ps

module testbench;

    localparam int DEPTH          = rrc_pkg::DEPTH_DEFAULT;
    localparam int KEY_W          = rrc_pkg::KEY_WIDTH_DEFAULT;
    localparam int VALUE_W        = rrc_pkg::VALUE_WIDTH_DEFAULT;
    localparam int CNT_W          = $clog2(rrc_pkg::DEPTH_DEFAULT + 1);
    localparam int IDX_W          = rrc_pkg::CFG_INDEX_W;
    localparam int DATA_W         = rrc_pkg::CFG_DATA_W;
    localparam int PHASES         = 10;
    localparam int PHASE_REQS     = 175;
    localparam int WATCHDOG_LIMIT = 1000;

    // register indexes with no register behind them
    localparam logic [IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic               is_cfg;
        logic               kind;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic [IDX_W-1:0]   cfg_index;
        logic [DATA_W-1:0]  cfg_data;
        logic               gapless;
    } t_cache_req;

    typedef struct packed {
        logic               hit;
        logic [VALUE_W-1:0] read_value;
        logic               evicted;
        logic [KEY_W-1:0]   evicted_key;
        logic [CNT_W-1:0]   entry_count;
    } t_lookup_result;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_start     = 1'b0;
    logic                   i_kind      = rrc_pkg::KIND_PUT;
    logic [KEY_W-1:0]       i_key       = '0;
    logic [VALUE_W-1:0]     i_value     = '0;
    logic                   i_cfg_we    = 1'b0;
    logic [IDX_W-1:0]       i_cfg_index = rrc_pkg::REG_CAPACITY;
    logic [DATA_W-1:0]      i_cfg_data  = '0;
    logic                   o_busy;
    logic                   o_result_valid;
    logic                   o_hit;
    logic [VALUE_W-1:0]     o_read_value;
    logic                   o_evicted;
    logic [KEY_W-1:0]       o_evicted_key;
    logic [CNT_W-1:0]       o_entry_count;

    random_replacement_cache dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_kind         (i_kind),
        .i_key          (i_key),
        .i_value        (i_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_hit          (o_hit),
        .o_read_value   (o_read_value),
        .o_evicted      (o_evicted),
        .o_evicted_key  (o_evicted_key),
        .o_entry_count  (o_entry_count)
    );

    always #5 i_clk = ~i_clk;

    t_cache_req     req_queue[$];
    t_lookup_result expected_results[$];
    logic           gapless_fill = 1'b0;
    logic           took_req     = 1'b0;
    int             fail_count   = 0;
    int             stall_cycles = 0;

    // shadow copy of the cache contents and registers
    logic [KEY_W-1:0]              shadow_key  [DEPTH];
    logic [VALUE_W-1:0]            shadow_val  [DEPTH];
    logic                          shadow_used [DEPTH];
    int                            shadow_count;
    logic [rrc_pkg::LFSR_W-1:0]    shadow_lfsr;
    logic [rrc_pkg::CAP_REG_W-1:0] shadow_cap;

    task automatic push_req(input logic kind, input logic [KEY_W-1:0] key,
                            input logic [VALUE_W-1:0] value);
        t_cache_req r;
        r         = '0;
        r.kind    = kind;
        r.key     = key;
        r.value   = value;
        r.gapless = gapless_fill;
        req_queue = {req_queue, r};
    endtask

    task automatic push_cfg(input logic [IDX_W-1:0] idx,
                            input logic [DATA_W-1:0] data);
        t_cache_req r;
        r           = '0;
        r.is_cfg    = 1'b1;
        r.cfg_index = idx;
        r.cfg_data  = data;
        req_queue   = {req_queue, r};
    endtask

    task automatic predict_lookup(input logic kind, input logic [KEY_W-1:0] key,
                                  input logic [VALUE_W-1:0] value,
                                  output t_lookup_result res);
        int          found;
        int          slot;
        int          cap;
        int unsigned prod;
        res   = '0;
        found = -1;
        for (int i = 0; i < DEPTH; i++) begin
            if (found < 0 && shadow_used[i] && shadow_key[i] == key) found = i;
        end
        res.hit = (found >= 0);
        if (kind == rrc_pkg::KIND_GET) begin
            if (found >= 0) res.read_value = shadow_val[found];
        end else if (found >= 0) begin
            shadow_val[found] = value;
        end else begin
            cap = int'(shadow_cap);
            if (cap == 0) cap = 1;
            if (cap > DEPTH) cap = DEPTH;
            if (shadow_count >= cap) begin
                // galois step, then scale the lfsr onto the capacity
                shadow_lfsr = shadow_lfsr[0] ? ((shadow_lfsr >> 1) ^ rrc_pkg::LFSR_MASK)
                                             : (shadow_lfsr >> 1);
                prod = shadow_lfsr * cap;
                slot = int'(prod >> 16);
                res.evicted     = 1'b1;
                res.evicted_key = shadow_key[slot];
            end else begin
                slot = shadow_count;
                shadow_count++;
            end
            shadow_key[slot]  = key;
            shadow_val[slot]  = value;
            shadow_used[slot] = 1'b1;
        end
        res.entry_count = CNT_W'(shadow_count);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %h, actual %h", name, want, got);
            fail_count++;
        end
    endtask

    // driver: one request or one register write at a time from the pending queue
    always @(negedge i_clk) begin
        t_cache_req head;
        logic       start_nxt;
        logic       we_nxt;
        start_nxt = i_start;
        we_nxt    = 1'b0;
        if (i_rst_n && !(i_start && !took_req)) begin
            start_nxt = 1'b0;
            if (req_queue.size() != 0) begin
                head = req_queue[0];
                if (head.is_cfg) begin
                    // registers only change once the cache has drained
                    if (!took_req && !o_busy && expected_results.size() == 0) begin
                        head        = req_queue.pop_front();
                        we_nxt      = 1'b1;
                        i_cfg_index <= head.cfg_index;
                        i_cfg_data  <= head.cfg_data;
                    end
                end else if (head.gapless || $urandom_range(99) >= 26) begin
                    head      = req_queue.pop_front();
                    start_nxt = 1'b1;
                    i_kind    <= head.kind;
                    i_key     <= head.key;
                    i_value   <= head.value;
                end
            end
        end
        i_start  <= start_nxt;
        i_cfg_we <= we_nxt;
    end

    // monitor: check strobed results, track register writes, predict accepted requests
    always @(posedge i_clk) begin
        t_lookup_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                shadow_key[i]  = '0;
                shadow_val[i]  = '0;
                shadow_used[i] = 1'b0;
            end
            shadow_count = 0;
            shadow_cap   = rrc_pkg::CAP_RESET;
            shadow_lfsr  = rrc_pkg::SEED_RESET;
            took_req     <= 1'b0;
        end else begin
            if (o_result_valid) begin
                if (expected_results.size() == 0) begin
                    $error("result strobed with no request outstanding");
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("hit", 32'(want.hit), 32'(o_hit));
                    check_field("read_value", want.read_value, o_read_value);
                    check_field("evicted", 32'(want.evicted), 32'(o_evicted));
                    check_field("evicted_key", want.evicted_key, o_evicted_key);
                    check_field("entry_count", 32'(want.entry_count), 32'(o_entry_count));
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == rrc_pkg::REG_CAPACITY) begin
                    shadow_cap = i_cfg_data[rrc_pkg::CAP_REG_W-1:0];
                end else if (i_cfg_index == rrc_pkg::REG_RANDOM_SEED) begin
                    shadow_lfsr = i_cfg_data[rrc_pkg::LFSR_W-1:0];
                end
            end
            if (i_start && !o_busy) begin
                predict_lookup(i_kind, i_key, i_value, want);
                expected_results = {expected_results, want};
            end
            took_req <= i_start && !o_busy;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_result_valid) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[random_replacement_cache] ERROR");
            $finish;
        end
    end

    initial begin
        logic [KEY_W-1:0]              pool [12];
        logic [KEY_W-1:0]              key;
        logic [DATA_W-1:0]             cfg_word;
        logic [rrc_pkg::CAP_REG_W-1:0] cap;
        int                            pool_n;
        int                            pick;

        // empty cache, key and value extremes, overwrite
        push_req(rrc_pkg::KIND_GET, '0, '1);
        push_req(rrc_pkg::KIND_PUT, '0, '1);
        push_req(rrc_pkg::KIND_PUT, '1, '0);
        push_req(rrc_pkg::KIND_GET, '1, '0);
        push_req(rrc_pkg::KIND_GET, '0, '0);
        push_req(rrc_pkg::KIND_PUT, '0, 32'h1234_5678);
        push_req(rrc_pkg::KIND_GET, '0, '1);

        // capacity zero acts as one, below the count, with a zero seed
        push_cfg(rrc_pkg::REG_CAPACITY, 16'h0000);
        push_cfg(rrc_pkg::REG_RANDOM_SEED, 16'h0000);
        push_req(rrc_pkg::KIND_PUT, 32'h0000_0005, 32'hA5A5_A5A5);
        push_req(rrc_pkg::KIND_PUT, 32'h0000_0006, 32'h5A5A_5A5A);
        push_req(rrc_pkg::KIND_GET, 32'h0000_0006, '0);
        push_req(rrc_pkg::KIND_GET, '1, '0);

        // upper data bits on a capacity write, all-ones seed
        push_cfg(rrc_pkg::REG_CAPACITY, 16'hFFF1);
        push_cfg(rrc_pkg::REG_RANDOM_SEED, 16'hFFFF);
        push_req(rrc_pkg::KIND_PUT, 32'h0000_0007, 32'hDEAD_BEEF);
        push_req(rrc_pkg::KIND_GET, 32'h0000_0005, '1);
        push_req(rrc_pkg::KIND_PUT, '1, 32'h8000_0001);
        push_req(rrc_pkg::KIND_GET, 32'h0000_0007, '0);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       cap = 4'd3;
                1:       cap = 4'd2;
                2:       cap = 4'd5;
                3:       cap = 4'd15;
                4:       cap = 4'd9;
                5:       cap = 4'd8;
                6:       cap = 4'd4;
                7:       cap = 4'd1;
                8:       cap = 4'd8;
                default: cap = 4'($urandom_range(8, 1));
            endcase
            cfg_word = 16'($urandom);
            cfg_word[rrc_pkg::CAP_REG_W-1:0] = cap;
            push_cfg(rrc_pkg::REG_CAPACITY, cfg_word);
            case (p)
                1:       push_cfg(rrc_pkg::REG_RANDOM_SEED, 16'h0001);
                5:       push_cfg(rrc_pkg::REG_RANDOM_SEED, 16'h0000);
                7:       push_cfg(rrc_pkg::REG_RANDOM_SEED, 16'hFFFF);
                default: push_cfg(rrc_pkg::REG_RANDOM_SEED, 16'($urandom_range(65535, 1)));
            endcase
            // writes to unmapped indexes must leave everything alone
            if (p == 3) push_cfg(REG_SPARE_LO, 16'($urandom));
            if (p == 7) push_cfg(REG_SPARE_HI, 16'($urandom));

            pool_n = $urandom_range(12, 2);
            for (int k = 0; k < pool_n; k++) pool[k] = $urandom;
            gapless_fill = (p == 4);
            for (int n = 0; n < PHASE_REQS; n++) begin
                pick = $urandom_range(99);
                if (pick < 80) key = pool[$urandom_range(pool_n - 1)];
                else if (pick < 90) key = $urandom;
                else if (pick < 95) key = '0;
                else key = '1;
                push_req(($urandom_range(99) < 45) ? rrc_pkg::KIND_GET : rrc_pkg::KIND_PUT,
                         key, $urandom);
            end
        end
        gapless_fill = 1'b0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (req_queue.size() != 0 || i_start || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);

        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("[random_replacement_cache] OK");
        end else begin
            $display("[random_replacement_cache] ERROR");
        end
        $finish;
    end

endmodule

// ===== random_replacement_cache.f =====
hdl/rrc_pkg.sv
hdl/rrc_entry_ram.sv
hdl/rrc_victim.sv
hdl/random_replacement_cache.sv
tb/sv/testbench.sv
